// File: src/xcpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xcpc_pkg: shared types and functions of the chained pixel cipher
// Holds the xorshift32 step, the GF(2) jump table and the types that the
// front, the queue and the back end exchange.
// ----------------------------------------------------------------------------
package xcpc_pkg;

  localparam int unsigned ShiftA    = 13;
  localparam int unsigned ShiftB    = 17;
  localparam int unsigned ShiftC    = 5;
  localparam int unsigned GenW      = 32;
  localparam int unsigned PixW      = 24;
  localparam int unsigned SkipBits  = 24;
  localparam int unsigned SkipIdxW  = $clog2(SkipBits);
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam logic [SkipIdxW-1:0] SkipLast = SkipIdxW'(SkipBits - 1);

  typedef enum logic [CfgIdxW-1:0] {
    REG_SEED    = 2'd0,
    REG_START   = 2'd1,
    REG_COUNT   = 2'd2,
    REG_DECRYPT = 2'd3
  } cfg_reg_e;

  // Column j of a matrix is the image of unit vector j.
  typedef logic [GenW-1:0][GenW-1:0] mat_t;
  typedef mat_t [SkipBits-1:0]       jump_tab_t;

  typedef struct packed {
    logic [GenW-1:0] seed;
    logic [PixW-1:0] start_value;
    logic [PixW-1:0] pixel_count;
    logic            decrypt_mode;
  } cfg_t;

  typedef struct packed {
    logic [PixW-1:0] pix;    // red, green, blue from high to low
    logic            last;
    logic            first;  // first pixel of an image
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic jumping;
  } back_stat_t;

  function automatic logic [GenW-1:0] xs_step(input logic [GenW-1:0] x);
    logic [GenW-1:0] y;
    y = x ^ (x << ShiftA);
    y = y ^ (y >> ShiftB);
    y = y ^ (y << ShiftC);
    return y;
  endfunction

  function automatic logic [GenW-1:0] mat_apply(input mat_t m, input logic [GenW-1:0] v);
    logic [GenW-1:0] r;
    r = '0;
    for (int j = 0; j < GenW; j++) begin
      if (v[j]) begin
        r = r ^ m[j];
      end
    end
    return r;
  endfunction

  // Entry b is the matrix of 2**b generator steps.
  function automatic jump_tab_t build_jump_tab();
    jump_tab_t tab;
    mat_t      p;
    mat_t      q;
    for (int j = 0; j < GenW; j++) begin
      p[j] = xs_step(GenW'(1) << j);
    end
    for (int b = 0; b < SkipBits; b++) begin
      tab[b] = p;
      for (int j = 0; j < GenW; j++) begin
        q[j] = mat_apply(p, p[j]);
      end
      p = q;
    end
    return tab;
  endfunction

  localparam jump_tab_t JumpTab = build_jump_tab();

endpackage
`default_nettype wire

// File: src/xcpc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xcpc_if: stream channels of the chained pixel cipher
// Pixel input channel, pixel output channel and register write channel.
// ----------------------------------------------------------------------------
interface xcpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic       in_last;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  output in_last, input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  input in_last, output ready);
endinterface

interface xcpc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       out_last;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_last, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input out_last, output ready);
endinterface

interface xcpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: src/xcpc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xcpc_front: pixel intake
// Accepts pixels, packs them and marks the first pixel of each image.
// ----------------------------------------------------------------------------
module xcpc_front
  import xcpc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  xcpc_in_if.sink    pix_i,
  input  fifo_stat_t q_stat_i,
  output logic       q_push_o,
  output q_entry_t   q_entry_o
);

  logic first_q, first_d;

  assign pix_i.ready = !q_stat_i.full;
  assign q_push_o    = pix_i.valid && pix_i.ready;

  assign q_entry_o.pix   = {pix_i.in_red, pix_i.in_green, pix_i.in_blue};
  assign q_entry_o.last  = pix_i.in_last;
  assign q_entry_o.first = first_q;

  // The pixel after one flagged last opens a new image.
  assign first_d = q_push_o ? pix_i.in_last : first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else begin
      first_q <= first_d;
    end
  end

endmodule
`default_nettype wire

// File: src/xcpc_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xcpc_fifo: two-entry queue
// Decouples pixel intake from the cipher back end.
// ----------------------------------------------------------------------------
module xcpc_fifo
  import xcpc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  q_entry_t   entry_i,
  input  logic       pop_i,
  output logic       valid_o,
  output q_entry_t   head_o,
  output fifo_stat_t stat_o
);

  q_entry_t   slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign valid_o      = !stat_o.empty;
  assign head_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

// File: src/xcpc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xcpc_back: keystream and chaining
// Jumps the generator at each image start, then masks and chains pixels.
// ----------------------------------------------------------------------------
module xcpc_back
  import xcpc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       q_valid_i,
  input  q_entry_t   q_head_i,
  output logic       q_pop_o,
  output back_stat_t stat_o,
  xcpc_out_if.source pix_o
);

  typedef enum logic [2:0] {
    BK_RUN   = 3'b001,
    BK_JUMP  = 3'b010,
    BK_FIRST = 3'b100
  } back_state_e;

  back_state_e         state_q, state_d;
  logic [SkipIdxW-1:0] bit_q, bit_d;
  logic [GenW-1:0]     gen_q, gen_d;
  logic [PixW-1:0]     chain_q, chain_d;
  logic                out_valid_q, out_valid_d;
  logic [PixW-1:0]     res_q;
  logic                last_q;

  logic            out_free;
  logic            fire;
  logic [GenW-1:0] key;
  logic [PixW-1:0] chain_sel;
  logic [PixW-1:0] res;

  assign out_free  = !out_valid_q || pix_o.ready;
  assign key       = xs_step(gen_q);
  assign chain_sel = q_head_i.first ? cfg_i.start_value : chain_q;
  assign res       = chain_sel ^ key[PixW-1:0] ^ q_head_i.pix;

  always_comb begin
    state_d     = state_q;
    bit_d       = bit_q;
    gen_d       = gen_q;
    chain_d     = chain_q;
    fire        = 1'b0;
    case (state_q)
      BK_RUN: begin
        if (q_valid_i && q_head_i.first) begin
          state_d = BK_JUMP;
          gen_d   = cfg_i.seed;
          bit_d   = '0;
        end else begin
          fire = q_valid_i && out_free;
        end
      end
      BK_JUMP: begin
        if (cfg_i.pixel_count[bit_q]) begin
          gen_d = mat_apply(JumpTab[bit_q], gen_q);
        end
        bit_d = bit_q + 1'b1;
        if (bit_q == SkipLast) begin
          state_d = BK_FIRST;
        end
      end
      BK_FIRST: begin
        fire = q_valid_i && out_free;
        if (fire) begin
          state_d = BK_RUN;
        end
      end
      default: begin
        state_d = BK_RUN;
      end
    endcase
    out_valid_d = out_valid_q && !pix_o.ready;
    if (fire) begin
      out_valid_d = 1'b1;
      gen_d       = key;
      chain_d     = cfg_i.decrypt_mode ? q_head_i.pix : res;
    end
  end

  assign q_pop_o        = fire;
  assign stat_o.jumping = (state_q == BK_JUMP);

  assign pix_o.valid     = out_valid_q;
  assign pix_o.out_red   = res_q[23:16];
  assign pix_o.out_green = res_q[15:8];
  assign pix_o.out_blue  = res_q[7:0];
  assign pix_o.out_last  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_RUN;
      bit_q       <= '0;
      gen_q       <= '0;
      chain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_q       <= bit_d;
      gen_q       <= gen_d;
      chain_q     <= chain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q  <= res;
      last_q <= q_head_i.last;
    end
  end

endmodule
`default_nettype wire

// File: src/xorshift_chained_pixel_cipher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xorshift_chained_pixel_cipher: xorshift32 keystream cipher with chaining
// Substitution stage of an image cipher on a stream of RGB pixels.
// ----------------------------------------------------------------------------
// Pixels enter on pix_i and leave on pix_o, one result item for every input
// item, in order. Inside an image the block takes and delivers one pixel per
// clock while pix_o is ready. The first pixel of each image (the one after an
// item flagged in_last, or the first after reset) waits while the back end
// loads the generator from seed, then jumps it ahead by pixel_count steps
// with one 32x32 GF(2) matrix-vector product per set bit of pixel_count, and
// then masks the pixel as usual. When no jump is due, a pixel taken from
// pix_i passes through the queue and the result register before it is
// offered on pix_o. A two-entry queue between the intake and the back end
// keeps the input side moving while a result waits on pix_o. Registers are
// written through cfg_i (index 0 seed, 1 start value, 2 pixel count, 3
// decrypt mode); the port is always ready, and writes belong to times when
// no item is in flight. In encrypt mode the chain carries the previous output
// pixel, in decrypt mode the previous input pixel; the first pixel of an
// image uses the start value instead.
// ----------------------------------------------------------------------------
module xorshift_chained_pixel_cipher
  import xcpc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  xcpc_cfg_if.sink   cfg_i,
  xcpc_in_if.sink    pix_i,
  xcpc_out_if.source pix_o
);

  // Configuration registers.
  logic [GenW-1:0] seed_q;
  logic [PixW-1:0] start_q;
  logic [PixW-1:0] count_q;
  logic            decrypt_q;
  logic            cfg_wr;
  cfg_t            cfg;

  // Queue between intake and back end.
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  q_entry_t   q_entry;
  q_entry_t   q_head;
  fifo_stat_t q_stat;
  back_stat_t bk_stat;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= '0;
      start_q   <= '0;
      count_q   <= PixW'(1);
      decrypt_q <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_SEED:    seed_q    <= cfg_i.data;
        REG_START:   start_q   <= cfg_i.data[PixW-1:0];
        REG_COUNT:   count_q   <= cfg_i.data[PixW-1:0];
        REG_DECRYPT: decrypt_q <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.seed         = seed_q;
  assign cfg.start_value  = start_q;
  assign cfg.pixel_count  = count_q;
  assign cfg.decrypt_mode = decrypt_q;

  xcpc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_i),
    .q_stat_i  (q_stat),
    .q_push_o  (q_push),
    .q_entry_o (q_entry)
  );

  xcpc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head),
    .stat_o  (q_stat)
  );

  xcpc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .stat_o    (bk_stat),
    .pix_o     (pix_o)
  );

  // The queue can never be full and empty at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // The intake only pushes into a queue with room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("push into a full queue");

  // The back end only pops a present entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("pop from an empty queue");

  // No pixel leaves the queue while the generator jump is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.jumping |-> !q_pop)
    else $error("pixel consumed during generator jump");

endmodule
`default_nettype wire
